/* rtl/text_console_cell_writer_assert.svh */
// Assertion macros used by the console checker file.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define TCCW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies an expression in the next.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/tccw_pkg.sv */
// Shared types, constants and command codes for the text console cell writer.
package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // Field widths
    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [BYTE_W-1:0] octet_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;

    // Request modes
    localparam mode_t MODE_PUT    = 2'd0;
    localparam mode_t MODE_CLEAR  = 2'd1;
    localparam mode_t MODE_SETCUR = 2'd2;
    localparam mode_t MODE_READ   = 2'd3;

    // Special characters
    localparam octet_t CH_NULL      = 8'h00;
    localparam octet_t CH_BACKSPACE = 8'h08;
    localparam octet_t CH_NEWLINE   = 8'h0A;
    localparam octet_t CH_SPACE     = 8'h20;

    localparam octet_t ATTR_RESET = 8'h02;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_BS,
        OP_NL,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t    op;
        octet_t ch;
        col_t   col;
        row_t   row;
        addr_t  addr;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

/* rtl/tccw_cmd_if.sv */
// Request channel carrying one console command.
interface tccw_cmd_if;
    import tccw_pkg::*;

    logic   valid;
    logic   ready;
    mode_t  mode;
    octet_t char_code;
    octet_t col;
    octet_t row;

    modport source (output valid, output mode, output char_code, output col, output row,
                    input ready);
    modport sink   (input valid, input mode, input char_code, input col, input row,
                    output ready);
    modport mon    (input valid, input ready, input mode, input char_code, input col,
                    input row);
endinterface

/* rtl/tccw_rsp_if.sv */
// Result channel carrying the cursor position and read cell data.
interface tccw_rsp_if;
    import tccw_pkg::*;

    logic  valid;
    logic  ready;
    col_t  cursor_col;
    row_t  cursor_row;
    addr_t cursor_linear;
    cell_t cell_data;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_linear, output cell_data, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_linear, input cell_data, output ready);
    modport mon    (input valid, input ready, input cursor_col, input cursor_row,
                    input cursor_linear, input cell_data);
endinterface

/* rtl/tccw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/tccw_front.sv */
// Front end: accept requests, classify them and saturate coordinates.
module tccw_front (
    tccw_cmd_if.sink       cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output tccw_pkg::cmd_t q_cmd
);
    import tccw_pkg::*;

    col_t col_sat;
    row_t row_sat;
    op_t  op;

    // Pass the request straight into the queue
    assign q_valid = cmd.valid;
    assign cmd.ready = q_ready;

    // Saturate coordinates to the last column and row
    always_comb
    begin
        col_sat = (cmd.col > octet_t'(COLUMNS - 1)) ? col_t'(COLUMNS - 1) : cmd.col[COL_W-1:0];
        row_sat = (cmd.row > octet_t'(ROWS - 1)) ? row_t'(ROWS - 1) : cmd.row[ROW_W-1:0];
    end

    // Classify the request
    always_comb
    begin
        op = OP_NOP;
        unique case (cmd.mode)
            MODE_PUT:
            begin
                unique case (cmd.char_code)
                    CH_NULL:      op = OP_NOP;
                    CH_BACKSPACE: op = OP_BS;
                    CH_NEWLINE:   op = OP_NL;
                    default:      op = OP_CHAR;
                endcase
            end
            MODE_CLEAR:  op = OP_CLEAR;
            MODE_SETCUR: op = OP_SETCUR;
            MODE_READ:   op = OP_READ;
        endcase
    end

    // Build the queue entry with the linear cell address
    always_comb
    begin
        q_cmd.op   = op;
        q_cmd.ch   = cmd.char_code;
        q_cmd.col  = col_sat;
        q_cmd.row  = row_sat;
        q_cmd.addr = addr_t'(addr_t'(row_sat) * addr_t'(COLUMNS)) + addr_t'(col_sat);
    end

endmodule

/* rtl/tccw_queue.sv */
// Short command queue between the front and back ends.
module tccw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tccw_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output tccw_pkg::cmd_t out_cmd
);
    import tccw_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/tccw_back.sv */
// Back end: carry out commands on the screen store and register results.
module tccw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  tccw_pkg::octet_t       cfg_wr_data,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  tccw_pkg::cmd_t         q_cmd,
    tccw_rsp_if.source             rsp
);
    import tccw_pkg::*;

    state_t state_reg;
    state_t state_next;
    col_t   cur_col_reg;
    col_t   cur_col_next;
    row_t   cur_row_reg;
    row_t   cur_row_next;
    addr_t  cur_lin_reg;
    addr_t  cur_lin_next;
    addr_t  idx_reg;
    addr_t  idx_next;
    logic   rd_flag_reg;
    logic   rd_flag_next;
    octet_t attr_reg;

    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    col_t   rsp_col_reg;
    row_t   rsp_row_reg;
    addr_t  rsp_lin_reg;
    cell_t  rsp_data_reg;
    cell_t  rsp_data_next;

    logic   ram_we;
    addr_t  ram_waddr;
    cell_t  ram_wdata;
    logic   ram_re;
    addr_t  ram_raddr;
    cell_t  ram_rdata;

    logic   out_free;
    logic   go;
    logic   last_col;
    logic   last_row;
    logic   load;
    cell_t  blank_cell;

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign go         = (state_reg == ST_IDLE) && q_valid && out_free;
    assign q_ready    = go;
    assign last_col   = (cur_col_reg == col_t'(COLUMNS - 1));
    assign last_row   = (cur_row_reg == row_t'(ROWS - 1));
    assign blank_cell = {attr_reg, CH_SPACE};

    // Screen store
    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    unique case (q_cmd.op)
                        OP_CHAR:
                        begin
                            if (last_col && last_row)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        OP_NL:
                        begin
                            if (last_row)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        OP_CLEAR: state_next = ST_FILL;
                        OP_READ:  state_next = ST_DONE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCROLL:
            begin
                if (idx_reg == addr_t'(CELL_COUNT))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (idx_reg == addr_t'(CELL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and store control per state
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = blank_cell;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        cur_lin_next = cur_lin_reg;
        idx_next     = idx_reg;
        rd_flag_next = rd_flag_reg;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    rd_flag_next = 1'b0;
                    load         = 1'b1;
                    unique case (q_cmd.op)
                        OP_CHAR:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_lin_reg;
                            ram_wdata = {attr_reg, q_cmd.ch};
                            if (last_col && last_row)
                            begin
                                // Wrap past the bottom: start a scroll
                                load         = 1'b0;
                                cur_col_next = '0;
                                cur_row_next = row_t'(ROWS - 1);
                                cur_lin_next = addr_t'(LAST_ROW_BASE);
                                idx_next     = addr_t'(COLUMNS);
                            end
                            else if (last_col)
                            begin
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + 1'b1;
                                cur_lin_next = cur_lin_reg + 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                                cur_lin_next = cur_lin_reg + 1'b1;
                            end
                        end
                        OP_BS:
                        begin
                            if (cur_col_reg != '0)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = cur_lin_reg - 1'b1;
                                cur_col_next = cur_col_reg - 1'b1;
                                cur_lin_next = cur_lin_reg - 1'b1;
                            end
                        end
                        OP_NL:
                        begin
                            if (last_row)
                            begin
                                load         = 1'b0;
                                cur_col_next = '0;
                                cur_row_next = row_t'(ROWS - 1);
                                cur_lin_next = addr_t'(LAST_ROW_BASE);
                                idx_next     = addr_t'(COLUMNS);
                            end
                            else
                            begin
                                cur_col_next = '0;
                                cur_row_next = cur_row_reg + 1'b1;
                                cur_lin_next = cur_lin_reg - addr_t'(cur_col_reg)
                                               + addr_t'(COLUMNS);
                            end
                        end
                        OP_CLEAR:
                        begin
                            load         = 1'b0;
                            cur_col_next = '0;
                            cur_row_next = '0;
                            cur_lin_next = '0;
                            idx_next     = '0;
                        end
                        OP_SETCUR:
                        begin
                            cur_col_next = q_cmd.col;
                            cur_row_next = q_cmd.row;
                            cur_lin_next = q_cmd.addr;
                        end
                        OP_READ:
                        begin
                            load         = 1'b0;
                            ram_re       = 1'b1;
                            ram_raddr    = q_cmd.addr;
                            rd_flag_next = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // Read one row down, write the previous read one row up
                ram_re    = (idx_reg != addr_t'(CELL_COUNT));
                ram_we    = (idx_reg > addr_t'(COLUMNS));
                ram_waddr = idx_reg - addr_t'(COLUMNS + 1);
                ram_wdata = ram_rdata;
                idx_next  = (idx_reg == addr_t'(CELL_COUNT)) ? addr_t'(LAST_ROW_BASE)
                                                             : idx_reg + 1'b1;
            end
            ST_FILL:
            begin
                // Blank one cell per cycle
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                load = out_free;
            end
        endcase
    end

    // Result register
    assign rsp_valid_next = load || (rsp_valid_reg && !rsp.ready);
    assign rsp_data_next  = ((state_reg == ST_DONE) && rd_flag_reg) ? ram_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_lin_reg   <= '0;
            idx_reg       <= '0;
            rd_flag_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            attr_reg      <= ATTR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_lin_reg   <= cur_lin_next;
            idx_reg       <= idx_next;
            rd_flag_reg   <= rd_flag_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the result payload until loaded again
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_col_reg  <= cur_col_next;
            rsp_row_reg  <= cur_row_next;
            rsp_lin_reg  <= cur_lin_next;
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_col    = rsp_col_reg;
    assign rsp.cursor_row    = rsp_row_reg;
    assign rsp.cursor_linear = rsp_lin_reg;
    assign rsp.cell_data     = rsp_data_reg;

endmodule

/* rtl/text_console_cell_writer.sv */
// Top level of the text console cell writer.
//
// Channel   Dir  Handshake      Payload
// cmd       in   valid/ready    mode, char_code, col, row
// rsp       out  valid/ready    cursor_col, cursor_row, cursor_linear, cell_data
// cfg       in   cfg_wr_en      cfg_wr_data (attribute byte)
//
// Put, set cursor and null finish in the back end's idle state; result valid the cycle after acceptance.
// Read cell passes through the done state, so the registered read of the screen RAM can return.
// Clear walks the fill state with one RAM write per cell, then the done state.
// Scroll adds a read/write copy pass, then the bottom row blanked.
// The screen RAM is not cleared at reset; cells read before a clear are undefined.
// A two-entry queue keeps accepting requests while the back end is busy or stalled, until it is full.
module text_console_cell_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  tccw_pkg::octet_t cfg_wr_data,
    tccw_cmd_if.sink         cmd,
    tccw_rsp_if.source       rsp
);
    import tccw_pkg::*;

    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;
    logic b_valid;
    logic b_ready;
    cmd_t b_cmd;

    tccw_front u_front (
        .cmd     (cmd),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_cmd   (f_cmd)
    );

    tccw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    tccw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_cmd       (b_cmd),
        .rsp         (rsp)
    );

endmodule

/* rtl/tccw_checker.sv */
// Port-level checker for the text console cell writer, with its bind.
`include "text_console_cell_writer_assert.svh"

module tccw_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input tccw_pkg::col_t  rsp_col,
    input tccw_pkg::row_t  rsp_row,
    input tccw_pkg::addr_t rsp_lin,
    input tccw_pkg::cell_t rsp_data
);
    import tccw_pkg::*;

    logic                                  stalled;
    logic [COL_W+ROW_W+ADDR_W+CELL_W-1:0]  payload;
    logic                                  lin_ok;
    logic                                  on_screen;

    assign stalled   = rsp_valid && !rsp_ready;
    assign payload   = {rsp_col, rsp_row, rsp_lin, rsp_data};
    assign lin_ok    = (rsp_lin == addr_t'(addr_t'(rsp_row) * addr_t'(COLUMNS))
                                   + addr_t'(rsp_col));
    assign on_screen = (rsp_col <= col_t'(COLUMNS - 1)) && (rsp_row <= row_t'(ROWS - 1));

    // Hold a stalled result
    `TCCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, stalled, rsp_valid, "result dropped while stalled")

    `TCCW_ASSERT_NEXT(a_rsp_stable, clk, rst_n, stalled, $stable(payload), "stalled result changed")

    // Linear position agrees with column and row
    `TCCW_ASSERT(a_linear, clk, rst_n, !rsp_valid || lin_ok, "cursor_linear mismatch")

    // Cursor stays on the screen
    `TCCW_ASSERT(a_range, clk, rst_n, !rsp_valid || on_screen, "cursor off screen")

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_col   (rsp.cursor_col),
    .rsp_row   (rsp.cursor_row),
    .rsp_lin   (rsp.cursor_linear),
    .rsp_data  (rsp.cell_data)
);
